// ----- rtl/lrd_pkg.sv -----
// Package for the log record deframer: phase and status codes, the framing
// state and result types, and the byte-wide CRC-32 update function.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package lrd_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [1:0] PH_LEN  = 2'd0;
  localparam logic [1:0] PH_CHK  = 2'd1;
  localparam logic [1:0] PH_PAY  = 2'd2;
  localparam logic [1:0] PH_STOP = 2'd3;

  localparam logic [2:0] ST_BUSY  = 3'd0;
  localparam logic [2:0] ST_GOOD  = 3'd1;
  localparam logic [2:0] ST_BAD   = 3'd2;
  localparam logic [2:0] ST_TORN  = 3'd3;
  localparam logic [2:0] ST_CLEAN = 3'd4;

  typedef struct packed {
    logic [1:0]  phase;
    logic [1:0]  header_count;
    logic [31:0] field_accum;
    logic [31:0] length_seen;
    logic [31:0] bytes_left;
    logic [31:0] stored_check;
    logic [31:0] running_check;
  } lrd_state_t;

  typedef struct packed {
    logic        emit;
    logic [7:0]  payload_byte;
    logic        byte_valid;
    logic        record_end;
    logic [2:0]  status;
    logic [31:0] record_length;
  } lrd_result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0] data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/lrd_step.sv -----
// Combinational framing step: header assembly, payload CRC update and the
// record-close decision for one accepted transfer.
// Depends on lrd_pkg.
`timescale 1ns / 1ps

module lrd_step import lrd_pkg::*; (
  input  lrd_state_t  state_i,
  input  logic [7:0]  data_byte,
  input  logic        end_of_log,
  output lrd_state_t  state_o,
  output lrd_result_t result_o
);

  logic [31:0] accum_shift;
  logic [31:0] crc_next;
  logic [31:0] left_dec;
  logic [2:0]  close_status;

  assign accum_shift = {state_i.field_accum[23:0], data_byte};
  assign crc_next    = crc_byte(state_i.running_check, data_byte);
  assign left_dec    = state_i.bytes_left - 32'd1;

  always_comb begin
    state_o      = state_i;
    result_o     = '0;
    close_status = ST_BUSY;
    if (state_i.phase != PH_STOP) begin
      if (end_of_log) begin
        result_o.emit       = 1'b1;
        result_o.record_end = 1'b1;
        if (state_i.phase == PH_LEN && state_i.header_count == 2'd0) begin
          result_o.status = ST_CLEAN;
        end else begin
          result_o.status = ST_TORN;
          if (state_i.phase != PH_LEN) begin
            result_o.record_length = state_i.length_seen;
          end
        end
        state_o.phase = PH_STOP;
      end else if (state_i.phase == PH_LEN || state_i.phase == PH_CHK) begin
        state_o.field_accum  = accum_shift;
        state_o.header_count = state_i.header_count + 2'd1;
        if (state_i.header_count == 2'd3) begin
          state_o.field_accum = '0;
          if (state_i.phase == PH_LEN) begin
            state_o.length_seen = accum_shift;
            state_o.phase       = PH_CHK;
          end else begin
            state_o.stored_check  = accum_shift;
            state_o.running_check = CRC_INIT;
            state_o.bytes_left    = state_i.length_seen;
            if (state_i.length_seen != 32'd0) begin
              state_o.phase = PH_PAY;
            end else begin
              close_status        = (accum_shift == 32'd0) ? ST_GOOD : ST_BAD;
              result_o.emit       = 1'b1;
              result_o.record_end = 1'b1;
              result_o.status     = close_status;
              state_o.phase       = (close_status == ST_GOOD) ? PH_LEN : PH_STOP;
            end
          end
        end
      end else begin
        state_o.running_check = crc_next;
        state_o.bytes_left    = left_dec;
        result_o.emit         = 1'b1;
        result_o.payload_byte = data_byte;
        result_o.byte_valid   = 1'b1;
        if (left_dec == 32'd0) begin
          close_status = ((crc_next ^ CRC_INIT) == state_i.stored_check) ?
                         ST_GOOD : ST_BAD;
          result_o.record_end    = 1'b1;
          result_o.status        = close_status;
          result_o.record_length = state_i.length_seen;
          state_o.running_check  = CRC_INIT;
          state_o.phase          = (close_status == ST_GOOD) ? PH_LEN : PH_STOP;
        end
      end
    end
  end

endmodule

// ----- rtl/log_record_deframer_crc_check_core.sv -----
// Top level of the log record deframer with CRC-32 check: framing state
// registers, the output register and the handshake control.
// Depends on lrd_pkg and lrd_step.
`timescale 1ns / 1ps

// Channel  Handshake              Payload
// in_      in_valid / in_ready    in_data_byte, in_end_of_log
// out_     out_valid / out_ready  out_payload_byte, out_byte_valid, out_record_end,
//                                 out_status, out_record_length
//
// Each input transfer is processed in the cycle it is accepted; its result, if
// any, appears in the output register on the next cycle, so one byte per cycle while the output is not stalled.
// The single-byte CRC update and the 32-bit counter compare set the cycle time.
// Reset returns the framer to the start of a length field with the CRC at all ones.
// While a result waits and out_ready is low, in_ready is held low.

module log_record_deframer_crc_check_core import lrd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_log,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_payload_byte,
  output logic        out_byte_valid,
  output logic        out_record_end,
  output logic [2:0]  out_status,
  output logic [31:0] out_record_length
);

  lrd_state_t  state_r;
  lrd_state_t  state_nxt;
  lrd_result_t result_nxt;
  lrd_result_t result_r;
  logic        out_valid_r;
  logic        in_xfer;

  assign in_ready = !out_valid_r || out_ready;
  assign in_xfer  = in_valid && in_ready;

  lrd_step u_step (
    .state_i    (state_r),
    .data_byte  (in_data_byte),
    .end_of_log (in_end_of_log),
    .state_o    (state_nxt),
    .result_o   (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase         <= PH_LEN;
      state_r.header_count  <= '0;
      state_r.field_accum   <= '0;
      state_r.length_seen   <= '0;
      state_r.bytes_left    <= '0;
      state_r.stored_check  <= '0;
      state_r.running_check <= CRC_INIT;
      out_valid_r           <= 1'b0;
    end else begin
      if (in_xfer) begin
        state_r <= state_nxt;
      end
      if (in_xfer) begin
        out_valid_r <= result_nxt.emit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && result_nxt.emit) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_payload_byte  = result_r.payload_byte;
  assign out_byte_valid    = result_r.byte_valid;
  assign out_record_end    = result_r.record_end;
  assign out_status        = result_r.status;
  assign out_record_length = result_r.record_length;

endmodule

// ----- verif/tb_log_record_deframer_crc_check_core.sv -----
// Self-checking testbench for log_record_deframer_crc_check_core: framed log
// records with good CRCs, then one ending (clean, torn or CRC mismatch).
// Depends on lrd_pkg and the RTL of the core; nothing else is read.
`timescale 1ns / 1ps

module tb_log_record_deframer_crc_check_core import lrd_pkg::*; ();

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] data;
    logic       eol;
    logic       hold;
  } log_item_t;

  typedef struct packed {
    logic [7:0]  pbyte;
    logic        bvalid;
    logic        rend;
    logic [2:0]  status;
    logic [31:0] rlen;
  } frame_result_t;

  typedef enum {END_CLEAN, END_TORN_LEN, END_TORN_CHK, END_TORN_PAY, END_BAD_PAY,
                END_BAD_EMPTY} log_end_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_end_of_log = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_payload_byte;
  logic        out_byte_valid;
  logic        out_record_end;
  logic [2:0]  out_status;
  logic [31:0] out_record_length;

  log_item_t     log_stream_q[$];
  frame_result_t frame_results_q[$];
  logic [7:0]    rec_body[$];

  // Shadow framing state.
  logic [1:0]  fr_phase = PH_LEN;
  logic [1:0]  fr_hdr_cnt = 2'd0;
  logic [31:0] fr_accum = 32'd0;
  logic [31:0] fr_len = 32'd0;
  logic [31:0] fr_left = 32'd0;
  logic [31:0] fr_crc_want = 32'd0;
  logic [31:0] fr_crc_run = CRC_INIT;

  int       errors = 0;
  int       sent_cnt = 0;
  int       taken_cnt = 0;
  int       result_cnt = 0;
  int       total_items = 1;
  int       good_records = 0;
  int       payload_cnt = 0;
  int       stall_cycles = 0;
  int       tx_idle_pct;
  int       rx_idle_pct;
  log_end_e ending;
  log_item_t     next_item;
  frame_result_t want;

  log_record_deframer_crc_check_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data_byte(in_data_byte),
    .in_end_of_log(in_end_of_log),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_payload_byte(out_payload_byte),
    .out_byte_valid(out_byte_valid),
    .out_record_end(out_record_end),
    .out_status(out_status),
    .out_record_length(out_record_length)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] crc32_feed(input logic [31:0] crc_in,
                                             input logic [7:0] d);
    logic [31:0] c;
    logic        fb;
    c = crc_in;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ d[i];
      c = c >> 1;
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

  task automatic push_item(input logic [7:0] d, input logic e, input logic h);
    log_item_t item;
    item = '{data: d, eol: e, hold: h};
    log_stream_q.insert(log_stream_q.size(), item);
  endtask

  task automatic push_be32(input logic [31:0] v, input logic h);
    push_item(v[31:24], 1'b0, h);
    push_item(v[23:16], 1'b0, 1'b0);
    push_item(v[15:8], 1'b0, 1'b0);
    push_item(v[7:0], 1'b0, 1'b0);
  endtask

  task automatic fill_body(input int n);
    rec_body.delete();
    repeat (n) rec_body.insert(rec_body.size(), 8'($urandom_range(0, 255)));
  endtask

  // Frames rec_body as one record; a non-zero crc_flip corrupts the stored CRC.
  task automatic frame_record(input logic [31:0] crc_flip, input logic h);
    logic [31:0] crc;
    crc = CRC_INIT;
    foreach (rec_body[i]) crc = crc32_feed(crc, rec_body[i]);
    push_be32(32'(rec_body.size()), h);
    push_be32((crc ^ CRC_INIT) ^ crc_flip, 1'b0);
    foreach (rec_body[i]) push_item(rec_body[i], 1'b0, 1'b0);
  endtask

  task automatic expect_result(input logic [7:0] pb, input logic bv, input logic re,
                               input logic [2:0] st, input logic [31:0] len);
    frame_result_t res;
    res = '{pbyte: pb, bvalid: bv, rend: re, status: st, rlen: len};
    frame_results_q.insert(frame_results_q.size(), res);
  endtask

  task automatic deframe_item(input logic [7:0] b, input logic eol);
    logic [2:0] st;
    if (fr_phase == PH_STOP) begin
      return;
    end
    if (eol) begin
      if (fr_phase == PH_LEN && fr_hdr_cnt == 2'd0) begin
        expect_result(8'd0, 1'b0, 1'b1, ST_CLEAN, 32'd0);
      end else begin
        expect_result(8'd0, 1'b0, 1'b1, ST_TORN, (fr_phase == PH_LEN) ? 32'd0 : fr_len);
      end
      fr_phase = PH_STOP;
      return;
    end
    if (fr_phase == PH_LEN || fr_phase == PH_CHK) begin
      fr_accum = {fr_accum[23:0], b};
      fr_hdr_cnt = fr_hdr_cnt + 2'd1;
      if (fr_hdr_cnt != 2'd0) begin
        return;
      end
      if (fr_phase == PH_LEN) begin
        fr_len = fr_accum;
        fr_accum = 32'd0;
        fr_phase = PH_CHK;
        return;
      end
      fr_crc_want = fr_accum;
      fr_accum = 32'd0;
      fr_crc_run = CRC_INIT;
      fr_left = fr_len;
      if (fr_len != 32'd0) begin
        fr_phase = PH_PAY;
        return;
      end
      st = (fr_crc_want == 32'd0) ? ST_GOOD : ST_BAD;
      expect_result(8'd0, 1'b0, 1'b1, st, 32'd0);
      fr_phase = (st == ST_GOOD) ? PH_LEN : PH_STOP;
      if (st == ST_GOOD) good_records++;
      return;
    end
    fr_crc_run = crc32_feed(fr_crc_run, b);
    fr_left = fr_left - 32'd1;
    payload_cnt++;
    if (fr_left != 32'd0) begin
      expect_result(b, 1'b1, 1'b0, ST_BUSY, 32'd0);
      return;
    end
    st = ((fr_crc_run ^ CRC_INIT) == fr_crc_want) ? ST_GOOD : ST_BAD;
    expect_result(b, 1'b1, 1'b1, st, fr_len);
    fr_phase = (st == ST_GOOD) ? PH_LEN : PH_STOP;
    if (st == ST_GOOD) good_records++;
    fr_crc_run = CRC_INIT;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("Mismatch on %s at result %0d: got %0h, expected %0h", what, result_cnt,
             got, exp_val);
    errors++;
  endtask

  // Driver and receiver: both change at the falling edge.
  always @(negedge clk) begin
    if (rst_n) begin
      if (taken_cnt * 3 < total_items) begin
        tx_idle_pct = 28;
        rx_idle_pct = 82;
      end else if (taken_cnt * 3 < total_items * 2) begin
        tx_idle_pct = 82;
        rx_idle_pct = 28;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      if (taken_cnt == sent_cnt) begin
        if (log_stream_q.size() != 0 &&
            !(log_stream_q[0].hold && frame_results_q.size() != 0) &&
            $urandom_range(0, 99) >= tx_idle_pct) begin
          next_item = log_stream_q.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= next_item.data;
          in_end_of_log <= next_item.eol;
          sent_cnt++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      deframe_item(in_data_byte, in_end_of_log);
      taken_cnt++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (frame_results_q.size() == 0) begin
        report_mismatch("result with none expected", {29'd0, out_status}, 32'd0);
      end else begin
        want = frame_results_q.pop_front();
        if (out_payload_byte !== want.pbyte)
          report_mismatch("payload_byte", 32'(out_payload_byte), 32'(want.pbyte));
        if (out_byte_valid !== want.bvalid)
          report_mismatch("byte_valid", 32'(out_byte_valid), 32'(want.bvalid));
        if (out_record_end !== want.rend)
          report_mismatch("record_end", 32'(out_record_end), 32'(want.rend));
        if (out_status !== want.status)
          report_mismatch("status", 32'(out_status), 32'(want.status));
        if (out_record_length !== want.rlen)
          report_mismatch("record_length", out_record_length, want.rlen);
      end
      result_cnt++;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int n;
    int k;
    logic [31:0] len;

    // Directed records: empty payload, then the two byte extremes.
    rec_body.delete();
    frame_record(32'd0, 1'b0);
    rec_body.delete();
    rec_body.insert(rec_body.size(), 8'h00);
    rec_body.insert(rec_body.size(), 8'hFF);
    frame_record(32'd0, 1'b0);

    // Random well-formed records; hold before the first and before each that starts at 901 to 919 queued bytes.
    while (log_stream_q.size() < 1800) begin
      k = $urandom_range(0, 99);
      if (k < 10) begin
        n = 0;
      end else if (k < 75) begin
        n = $urandom_range(1, 8);
      end else if (k < 96) begin
        n = $urandom_range(9, 40);
      end else begin
        n = $urandom_range(41, 120);
      end
      fill_body(n);
      frame_record(32'd0, (log_stream_q.size() == 18) ||
                          (log_stream_q.size() > 900 && log_stream_q.size() < 920));
    end

    // The log ends once; every ending stops the framer for good.
    ending = log_end_e'($urandom_range(0, 5));
    case (ending)
      END_CLEAN: begin
        push_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      end
      END_TORN_LEN: begin
        repeat ($urandom_range(1, 3)) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        push_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      end
      END_TORN_CHK: begin
        push_be32(32'($urandom_range(0, 300)), 1'b0);
        repeat ($urandom_range(0, 3)) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        push_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      end
      END_TORN_PAY: begin
        len = $urandom_range(0, 1) ? 32'hFFFF_FFFF : ($urandom | 32'h100);
        push_be32(len, 1'b0);
        push_be32($urandom, 1'b0);
        repeat ($urandom_range(0, 5)) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        push_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      end
      END_BAD_PAY: begin
        fill_body($urandom_range(1, 20));
        frame_record(32'd1 << $urandom_range(0, 31), 1'b0);
      end
      default: begin
        rec_body.delete();
        frame_record($urandom | 32'd1, 1'b0);
      end
    endcase
    repeat (3) push_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
    total_items = log_stream_q.size();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (log_stream_q.size() != 0 || taken_cnt != sent_cnt || frame_results_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d log bytes, %0d good records, %0d payload bytes.",
             taken_cnt, good_records, payload_cnt);
    $display("The log ended by %s; %0d results were checked.", ending.name(), result_cnt);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
